[design/assert_macros.svh]
// Assertion macros for the port checker of the resampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/lirs_pkg.sv]
// Types and constants of the linear-interpolation resampler.
`timescale 1ns / 1ps

package lirs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int ONE_Q       = 1 << FRAC_BITS;
  localparam int HALF_Q      = 1 << (FRAC_BITS - 1);
  localparam int STEP_W      = 21;
  localparam int CCNT_W      = 4;
  localparam int CH_W        = 3;
  localparam int POS_W       = 22;
  localparam int CFG_DATA_W  = 21;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_Q16      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = CFG_INDEX_W'(1);

  localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(65536);
  localparam logic [CCNT_W-1:0] CCOUNT_RESET = CCNT_W'(2);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [CH_W-1:0]               channel;
    logic                          final_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CH_W-1:0]               out_channel;
    logic                          last_of_run;
    logic                          stream_done;
  } out_item_t;

  // Control from the sequencer to the shared multiply unit.
  typedef struct packed {
    logic op_load;
    logic mul_en;
    logic tail;
  } mac_ctl_t;

endpackage

[design/lirs_mac.sv]
// Shared multiply unit: operand stage, product register, rounding and saturation.
`timescale 1ns / 1ps

module lirs_mac (
  input  logic                                     clk,
  input  lirs_pkg::mac_ctl_t                       ctl,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0]  older_sample,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0]  newer_sample,
  input  logic [lirs_pkg::FRAC_BITS:0]             frac,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0]  result
);
  import lirs_pkg::*;

  localparam int OPA_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 3;
  localparam int SHR_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = SHR_W + 1;
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

  logic signed [OPA_W-1:0]       op_a_r;
  logic [FRAC_BITS:0]            op_b_r;
  logic signed [SAMPLE_BITS-1:0] base_r;
  logic signed [PROD_W-1:0]      prod_r;

  logic signed [OPA_W-1:0]  diff;
  logic signed [PROD_W-1:0] mul_full;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SHR_W-1:0]  shr;
  logic signed [SUM_W-1:0]  sum;

  assign diff     = OPA_W'(newer_sample) - OPA_W'(older_sample);
  assign mul_full = PROD_W'(op_a_r) * PROD_W'($signed({1'b0, op_b_r}));
  assign rnd      = prod_r + $signed(PROD_W'(HALF_Q));
  assign shr      = rnd[PROD_W-1:FRAC_BITS];
  assign sum      = SUM_W'(base_r) + SUM_W'(shr);

  always_comb begin
    priority if (sum > SMAX) begin
      result = SMAX[SAMPLE_BITS-1:0];
    end else if (sum < SMIN) begin
      result = SMIN[SAMPLE_BITS-1:0];
    end else begin
      result = sum[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op_load) begin
      // The tail of a stream scales the last frame alone, with no offset.
      if (ctl.tail) begin
        op_a_r <= OPA_W'(older_sample);
        base_r <= '0;
      end else begin
        op_a_r <= diff;
        base_r <= older_sample;
      end
      op_b_r <= frac;
    end
    if (ctl.mul_en) begin
      prod_r <= mul_full;
    end
  end

endmodule

[design/linear_interp_resampler_top.sv]
// Top level of the streaming multichannel linear-interpolation resampler.
`timescale 1ns / 1ps

// Usage: samples enter interleaved on the in_ channel, one channel per transfer,
// with the channel index and a final-frame flag. When the sample of the highest
// channel arrives, the frame is complete and the block emits every output
// position that falls between the previous frame and this one, each position
// as one result per channel, on the out_ channel. A sample whose channel is not
// below the channel count is dropped. The last result of a run carries
// last_of_run, and the last result of a stream also carries stream_done.
// Timing: a sample that does not complete a frame is taken without a stall. A
// completed frame holds in_stall high while its results are produced and the
// frame store is updated. The first frame of a stream only primes the store,
// and as a final frame it also emits the tail results. The first result of an
// interpolation run passes the check, operand, multiply and output states
// before it is registered. All products go through one multiplier in lirs_mac.
// A result sits in the output register until it is taken; while the receiver
// stalls, the sequencer waits on that register and nothing is lost. Reset
// (synchronous, active low) clears both frame stores and the position, and
// restores step_q16 to 1.0 and channel_count to 2. Configuration is written
// through cfg_we, cfg_index and cfg_wdata; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module linear_interp_resampler_top #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_UPSAMPLE = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lirs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lirs_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [lirs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lirs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lirs_pkg::*;

  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(ONE_Q / MAX_UPSAMPLE);
  localparam logic [CCNT_W-1:0] MAX_CNT  = CCNT_W'(MAX_CHANNELS);
  localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(ONE_Q);
  localparam logic [POS_W-1:0]  POS_TWO  = POS_W'(2 * ONE_Q);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_OPS,
    S_MUL,
    S_OUT,
    S_COPY
  } state_t;

  state_t                         state_r;
  logic [STEP_W-1:0]              step_r;
  logic [CCNT_W-1:0]              ccount_r;
  logic signed [SAMPLE_BITS-1:0]  older_r [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0]  newer_r [MAX_CHANNELS];
  logic [POS_W-1:0]               pos_r;
  logic                           have_first_r;
  logic                           fin_r;
  logic                           tail_r;
  logic [CH_IDX_W-1:0]            chan_r;
  logic                           out_valid_r;
  out_item_t                      out_data_r;

  logic [CCNT_W-1:0]              cnt_eff;
  logic [STEP_W-1:0]              step_eff;
  logic                           in_acc;
  logic                           in_ch_ok;
  logic                           frame_done;
  logic [CH_IDX_W-1:0]            last_ch;
  logic                           chan_last;
  logic [POS_W-1:0]               pos_sum;
  logic                           more_pos;
  logic                           run_end;
  logic                           out_free;
  logic                           out_load;
  logic [FRAC_BITS:0]             frac;
  mac_ctl_t                       mac_ctl;
  logic signed [SAMPLE_BITS-1:0]  mac_result;

  // A channel count of zero acts as one; a count above the store depth is capped.
  always_comb begin
    priority if (ccount_r == '0) begin
      cnt_eff = CCNT_W'(1);
    end else if (ccount_r > MAX_CNT) begin
      cnt_eff = MAX_CNT;
    end else begin
      cnt_eff = ccount_r;
    end
  end

  // The step never falls below the deepest supported upsampling.
  assign step_eff   = (step_r < MIN_STEP) ? MIN_STEP : step_r;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign in_ch_ok   = (CCNT_W'(in_data.channel) < cnt_eff);
  assign frame_done = in_ch_ok && (CCNT_W'(in_data.channel) == (cnt_eff - CCNT_W'(1)));

  assign last_ch    = CH_IDX_W'(cnt_eff - CCNT_W'(1));
  assign chan_last  = (chan_r == last_ch);
  assign pos_sum    = pos_r + POS_W'(step_eff);

  // Whether another position follows the current one in this run. During the
  // interpolation of a final frame the tail positions count as well.
  always_comb begin
    if (tail_r) begin
      more_pos = (pos_sum < POS_ONE);
    end else begin
      more_pos = (pos_sum < POS_ONE) || (fin_r && (pos_sum < POS_TWO));
    end
  end
  assign run_end  = chan_last && !more_pos;
  assign out_free = !out_valid_r || !out_stall;
  // The output register takes a new result in this cycle.
  assign out_load = (state_r == S_OUT) && out_free;

  // Interpolation weights the difference by the fraction; the tail weights
  // the last frame by one minus the fraction.
  assign frac = tail_r ? ((FRAC_BITS + 1)'(ONE_Q) - pos_r[FRAC_BITS:0])
                       : {1'b0, pos_r[FRAC_BITS-1:0]};

  assign mac_ctl.op_load = (state_r == S_OPS);
  assign mac_ctl.mul_en  = (state_r == S_MUL);
  assign mac_ctl.tail    = tail_r;

  lirs_mac u_mac (
    .clk          (clk),
    .ctl          (mac_ctl),
    .older_sample (older_r[chan_r]),
    .newer_sample (newer_r[chan_r]),
    .frac         (frac),
    .result       (mac_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= STEP_RESET;
      ccount_r     <= CCOUNT_RESET;
      pos_r        <= '0;
      have_first_r <= 1'b0;
      fin_r        <= 1'b0;
      tail_r       <= 1'b0;
      chan_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        older_r[i] <= '0;
        newer_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_Q16:      step_r   <= cfg_wdata[STEP_W-1:0];
          CFG_CHANNEL_COUNT: ccount_r <= cfg_wdata[CCNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch_ok) begin
            newer_r[in_data.channel[CH_IDX_W-1:0]] <= in_data.sample_in;
            if (frame_done) begin
              fin_r  <= in_data.final_frame;
              tail_r <= 1'b0;
              chan_r <= '0;
              state_r <= have_first_r ? S_CHECK : S_COPY;
            end
          end
        end
        S_CHECK: begin
          if (pos_r < POS_ONE) begin
            state_r <= S_OPS;
          end else if (!tail_r) begin
            // Interpolation is done; the position moves on by one frame.
            pos_r   <= pos_r - POS_ONE;
            state_r <= S_COPY;
          end else begin
            // The stream is over: start the next one from scratch.
            pos_r        <= '0;
            have_first_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        S_OPS: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.sample_out  <= mac_result;
            out_data_r.out_channel <= CH_W'(chan_r);
            out_data_r.last_of_run <= run_end;
            out_data_r.stream_done <= run_end && fin_r;
            if (chan_last) begin
              chan_r  <= '0;
              pos_r   <= pos_sum;
              state_r <= S_CHECK;
            end else begin
              chan_r  <= chan_r + CH_IDX_W'(1);
              state_r <= S_OPS;
            end
          end
        end
        S_COPY: begin
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            older_r[i] <= newer_r[i];
          end
          have_first_r <= 1'b1;
          if (fin_r) begin
            tail_r  <= 1'b1;
            chan_r  <= '0;
            state_r <= S_CHECK;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/lirs_port_checker.sv]
// Port-level checker for the resampler and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lirs_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lirs_pkg::out_item_t out_data
);
  import lirs_pkg::*;

  `LIRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `LIRS_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
  `LIRS_ASSERT_IMP(a_done_ends_run, clk, rst_n, out_valid && out_data.stream_done, out_data.last_of_run)
  `LIRS_ASSERT_IMP(a_busy_mid_run, clk, rst_n, out_valid && !out_stall && !out_data.last_of_run, in_stall)

endmodule

bind linear_interp_resampler_top lirs_port_checker u_lirs_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[sim/tb_linear_interp_resampler_top.sv]
// Self-checking testbench for the linear-interpolation resampler top level.
`timescale 1ns / 1ps

module tb_linear_interp_resampler_top;
  import lirs_pkg::*;

  // These mirror the default parameters of the block under test.
  localparam int MAX_CH = 8;
  localparam int MAX_UP = 4;
  localparam longint MIN_STEP = ONE_Q / MAX_UP;
  // A frame that produces no result keeps the block busy after its transfer;
  // this pause covers that before any register write.
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_STEP_Q16;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Samples waiting to be offered to the block, filled by the stimulus process.
  in_item_t  pending_samples[$];
  // Interpolated samples the block owes us, oldest first.
  out_item_t interp_results_due[$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  // Percentage of cycles in which the sender idles, and of cycles in which the receiver stalls.
  int unsigned idle_pct = 8;

  // Shadow of the block's registers and stream state, kept by the predictor.
  logic [STEP_W-1:0]             step_setting = STEP_RESET;
  logic [CCNT_W-1:0]             chan_setting = CCOUNT_RESET;
  logic signed [SAMPLE_BITS-1:0] prev_frame[MAX_CH] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] cur_frame[MAX_CH] = '{default: '0};
  longint                        out_pos = 0;
  bit                            primed = 1'b0;

  linear_interp_resampler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A count of zero behaves as one channel and counts above the store size
  // are clamped to it.
  function automatic int unsigned active_channels();
    if (chan_setting == 0) return 1;
    if (chan_setting > MAX_CH) return MAX_CH;
    return chan_setting;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] saturate(input longint v);
    longint hi;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    if (v > hi) return SAMPLE_BITS'(hi);
    if (v < -hi - 1) return SAMPLE_BITS'(-hi - 1);
    return SAMPLE_BITS'(v);
  endfunction

  function automatic void queue_result(input longint v, input int unsigned ch);
    out_item_t r;
    r.sample_out  = saturate(v);
    r.out_channel = CH_W'(ch);
    r.last_of_run = 1'b0;
    r.stream_done = 1'b0;
    interp_results_due.push_back(r);
  endfunction

  // Works out every interpolated sample that one accepted transfer causes.
  // The arithmetic shift of a signed value floors, so adding half an LSB
  // first rounds half up.
  task automatic interpolate_frame(input in_item_t it);
    int unsigned cnt, ch, c, n_before;
    longint stp, a, d, g;
    out_item_t r;
    cnt = active_channels();
    stp = step_setting;
    if (stp < MIN_STEP) stp = MIN_STEP;
    ch = it.channel;
    if (ch >= cnt) return;
    cur_frame[ch] = it.sample_in;
    if (ch != cnt - 1) return;
    n_before = interp_results_due.size();
    if (primed) begin
      while (out_pos < ONE_Q) begin
        for (c = 0; c < cnt; c++) begin
          a = prev_frame[c];
          d = longint'(cur_frame[c]) - a;
          queue_result(a + ((d * out_pos + HALF_Q) >>> FRAC_BITS), c);
        end
        out_pos += stp;
      end
      out_pos -= ONE_Q;
    end
    prev_frame = cur_frame;
    primed = 1'b1;
    if (it.final_frame) begin
      // The tail fades the last frame toward zero over the remaining positions.
      while (out_pos < ONE_Q) begin
        g = ONE_Q - out_pos;
        for (c = 0; c < cnt; c++)
          queue_result((longint'(prev_frame[c]) * g + HALF_Q) >>> FRAC_BITS, c);
        out_pos += stp;
      end
      out_pos = 0;
      primed = 1'b0;
    end
    if (interp_results_due.size() > n_before) begin
      r = interp_results_due.pop_back();
      r.last_of_run = 1'b1;
      r.stream_done = it.final_frame;
      interp_results_due.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Input driver. The prediction is made at the edge where a transfer happens,
  // from the payload that was on the bus at that edge. A stalled payload is
  // held; otherwise the next sample goes out unless this cycle idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) interpolate_frame(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every transfer on the result side is checked field by
  // field against the oldest expectation, and the receiver stalls at random.
  always @(posedge clk) begin : result_monitor
    out_item_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (interp_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: sample %0d channel %0d",
                                    out_data.sample_out, out_data.out_channel));
        end else begin
          due = interp_results_due.pop_front();
          if (out_data.sample_out !== due.sample_out)
            report_mismatch($sformatf("sample_out %0d, expected %0d (channel %0d)",
                                      out_data.sample_out, due.sample_out,
                                      due.out_channel));
          if (out_data.out_channel !== due.out_channel)
            report_mismatch($sformatf("out_channel %0d, expected %0d",
                                      out_data.out_channel, due.out_channel));
          if (out_data.last_of_run !== due.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      out_data.last_of_run, due.last_of_run));
          if (out_data.stream_done !== due.stream_done)
            report_mismatch($sformatf("stream_done %0b, expected %0b",
                                      out_data.stream_done, due.stream_done));
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** linear_interp_resampler_top: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [SAMPLE_BITS-1:0] s,
                                         input int unsigned ch, input bit fin);
    in_item_t it;
    it.sample_in   = s;
    it.channel     = CH_W'(ch);
    it.final_frame = fin;
    return it;
  endfunction

  // Full-scale values, small values of either sign, and anything at all.
  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    logic [7:0] lsb;
    lsb = 8'($urandom);
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return {{16{lsb[7]}}, lsb};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Register writes only happen while the block is idle, so the shadow copy
  // can be updated as soon as the write is on the port.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STEP_Q16) step_setting = val[STEP_W-1:0];
    else chan_setting = val[CCNT_W-1:0];
  endtask

  // Waits until every sample has been sent and every result taken, then lets
  // the block finish any frame that produced nothing.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || interp_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queues a stream of whole frames in channel order. A few samples are
  // disturbed: a dropped sample on an unused channel, a stray final flag, or
  // a sample written to the wrong slot. An open stream has no final frame.
  task automatic queue_stream(input int unsigned frames, input bit closed,
                              inout int unsigned made);
    int unsigned cnt, fr, c, roll;
    in_item_t it;
    cnt = active_channels();
    for (fr = 0; fr < frames; fr++) begin
      for (c = 0; c < cnt; c++) begin
        roll = $urandom_range(99);
        if (roll < 4 && cnt < MAX_CH)
          pending_samples.push_back(make_item(random_sample(),
                                              $urandom_range(MAX_CH - 1, cnt),
                                              1'($urandom_range(1))));
        it = make_item(random_sample(), c, closed && fr == frames - 1 && c == cnt - 1);
        if (roll >= 4 && roll < 7) it.final_frame = 1'($urandom_range(1));
        else if (roll >= 7 && roll < 10) it.channel = CH_W'($urandom_range(cnt - 1));
        pending_samples.push_back(it);
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [STEP_W-1:0] step, input logic [CCNT_W-1:0] count,
                           input int unsigned target, input bit closed);
    int unsigned made;
    made = 0;
    write_reg(CFG_STEP_Q16, CFG_DATA_W'(step));
    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(count));
    while (made < target) queue_stream($urandom_range(1, 5), 1'b1, made);
    if (!closed) queue_stream(2, 1'b0, made);
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned c;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: unity step, two channels.
    // The first frame only primes the store; the second passes it through.
    pending_samples.push_back(make_item(24'h7FFFFF, 0, 1'b0));
    pending_samples.push_back(make_item(24'h800000, 1, 1'b0));
    pending_samples.push_back(make_item(24'h800000, 0, 1'b0));
    pending_samples.push_back(make_item(24'h7FFFFF, 1, 1'b0));
    // A channel beyond the count is dropped, final flag and all.
    pending_samples.push_back(make_item(24'h123456, 5, 1'b1));
    // Highest channel first: the frame completes with the stale lower slot.
    pending_samples.push_back(make_item(24'hFFFFFF, 1, 1'b0));
    // A final flag on a sample that does not complete the frame has no effect.
    pending_samples.push_back(make_item(24'h000001, 0, 1'b1));
    pending_samples.push_back(make_item(24'hFFFFFE, 1, 1'b0));
    // Final frame: one interpolated position plus the fading tail.
    pending_samples.push_back(make_item(24'h400000, 0, 1'b0));
    pending_samples.push_back(make_item(24'hC00000, 1, 1'b1));
    wait_idle();

    // Smallest step with all eight channels gives the longest runs.
    write_reg(CFG_STEP_Q16, CFG_DATA_W'(MIN_STEP));
    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(MAX_CH));
    for (c = 0; c < MAX_CH; c++)
      pending_samples.push_back(make_item(c[0] ? 24'h800000 : 24'h7FFFFF, c, 1'b0));
    for (c = 0; c < MAX_CH; c++)
      pending_samples.push_back(make_item(c[0] ? 24'h7FFFFF : 24'h800000, c,
                                          c == MAX_CH - 1));
    wait_idle();

    // Random part: streams with random content and a few disturbed samples over a
    // range of settings. Some phases leave a stream open, so the next settings take
    // effect in the middle of it.
    run_phase(21'd60211, 4'd2, 20, 1'b1);
    run_phase(21'd0, 4'd0, 20, 1'b1);
    run_phase(21'd65536, 4'd1, 20, 1'b0);
    run_phase(21'd1048576, 4'd3, 20, 1'b1);
    run_phase(21'h1FFFFF, 4'd15, 20, 1'b1);
    // A long stretch with no idling on either side.
    idle_pct = 0;
    run_phase(STEP_W'($urandom_range(131072, 16384)), CCNT_W'($urandom_range(8, 1)),
              40, 1'b1);
    idle_pct = 8;
    run_phase(21'd16384, 4'd8, 20, 1'b1);
    run_phase(21'd100, 4'd9, 20, 1'b0);
    run_phase(STEP_W'($urandom_range(262143, 0)), CCNT_W'($urandom_range(15, 0)),
              20, 1'b1);
    run_phase(STEP_W'($urandom_range(98304, 16384)), CCNT_W'($urandom_range(8, 1)),
              20, 1'b1);

    wait_idle();
    if (mismatches == 0 && interp_results_due.size() == 0) begin
      $display("** linear_interp_resampler_top: PASSED **");
    end else begin
      $display("** linear_interp_resampler_top: FAILED **");
    end
    $finish;
  end

endmodule
